@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers included by etm_matrix_unit
// Properties are sampled on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/etm_pkg.sv @@
// ----------------------------------------------------------------------------
// etm_pkg: shared types and constants for the model matrix block
// CORDIC table, fixed-point constants and the cell payload type.
// ----------------------------------------------------------------------------
package etm_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_COUNT    = 30;
   localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
   localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;

   function automatic logic signed [33:0] atan_lookup(input int i);
      logic signed [33:0] t;
      case (i)
         0: t = 34'sd536870912;   1: t = 34'sd316933406;
         2: t = 34'sd167458907;   3: t = 34'sd85004756;
         4: t = 34'sd42667331;    5: t = 34'sd21354465;
         6: t = 34'sd10679838;    7: t = 34'sd5340245;
         8: t = 34'sd2670163;     9: t = 34'sd1335087;
         10: t = 34'sd667544;     11: t = 34'sd333772;
         12: t = 34'sd166886;     13: t = 34'sd83443;
         14: t = 34'sd41722;      15: t = 34'sd20861;
         16: t = 34'sd10430;      17: t = 34'sd5215;
         18: t = 34'sd2608;       19: t = 34'sd1304;
         20: t = 34'sd652;        21: t = 34'sd326;
         22: t = 34'sd163;        23: t = 34'sd81;
         24: t = 34'sd41;         25: t = 34'sd20;
         26: t = 34'sd10;         27: t = 34'sd5;
         28: t = 34'sd3;          29: t = 34'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

   // one CORDIC lane state: x, y in Q1.30 with headroom, residual angle
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               neg;
   } lane_type;

   typedef struct packed {
      logic               vld;
      lane_type [2:0]     lane;
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [31:0] scl_x, scl_y, scl_z;
   } cell_type;

endpackage

@@ sv/euler_trs_model_matrix_top.sv @@
// Each input item yields four results on the result channel, one per cycle while
// rsp_ready is high; the CORDIC cell chain is fully pipelined and accepts new
// items while earlier results drain, until an item waits in matrix stage C for
// the busy hold register.
// Reset clears all valid flags, the busy flag and the row counter; no other state.
// ----------------------------------------------------------------------------
// euler_trs_model_matrix_top: model matrix and forward vector from TRS input
// A chain of CORDIC cells feeds the matrix unit that emits four rows.
// ----------------------------------------------------------------------------
module euler_trs_model_matrix_top
   import etm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0]        req_angle_x,
   input  logic [15:0]        req_angle_y,
   input  logic [15:0]        req_angle_z,
   input  logic signed [31:0] req_scale_x,
   input  logic signed [31:0] req_scale_y,
   input  logic signed [31:0] req_scale_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_elem_0,
   output logic signed [31:0] rsp_elem_1,
   output logic signed [31:0] rsp_elem_2,
   output logic signed [31:0] rsp_elem_3,
   output logic               rsp_last
);

   cell_type chain [NUM_STAGES+1];
   logic     adv;

   function automatic lane_type pre_rot(input logic [15:0] a);
      lane_type l;
      logic signed [33:0] z;
      z = 34'(signed'({a, 16'h0000}));
      l.neg = 1'b0;
      if (z > QUARTER_TURN) begin
         z = z - (QUARTER_TURN <<< 1);
         l.neg = 1'b1;
      end else if (z < -QUARTER_TURN) begin
         z = z + (QUARTER_TURN <<< 1);
         l.neg = 1'b1;
      end
      l.x = INV_GAIN_Q30;
      l.y = '0;
      l.z = z;
      return l;
   endfunction

   assign req_ready = adv;

   always_comb begin
      chain[0].vld     = req_valid;
      chain[0].lane[0] = pre_rot(req_angle_x);
      chain[0].lane[1] = pre_rot(req_angle_y);
      chain[0].lane[2] = pre_rot(req_angle_z);
      chain[0].pos_x   = req_pos_x;
      chain[0].pos_y   = req_pos_y;
      chain[0].pos_z   = req_pos_z;
      chain[0].scl_x   = req_scale_x;
      chain[0].scl_y   = req_scale_y;
      chain[0].scl_z   = req_scale_z;
   end

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
      etm_cordic_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .stage_i (5'(i)),
         .cell_i  (chain[i]),
         .cell_o  (chain[i+1])
      );
   end

   etm_matrix_unit u_mat (
      .clock         (clock),
      .reset         (reset),
      .cell_i        (chain[NUM_STAGES]),
      .take          (adv),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_elem_0    (rsp_elem_0),
      .rsp_elem_1    (rsp_elem_1),
      .rsp_elem_2    (rsp_elem_2),
      .rsp_elem_3    (rsp_elem_3),
      .rsp_last      (rsp_last)
   );

endmodule

@@ sv/etm_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// etm_cordic_cell: one CORDIC micro-rotation for three angle lanes
// Registers the rotated lanes and carries the pass-through payload.
// ----------------------------------------------------------------------------
module etm_cordic_cell
   import etm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic [4:0] stage_i,
   input  cell_type   cell_i,
   output cell_type   cell_o
);

   cell_type cell_ff, cell_in;
   logic signed [33:0] atan_val;

   // stage index is tied off per instance, so shifts and table reduce to wiring
   assign atan_val = atan_lookup(int'(stage_i));

   always_comb begin
      cell_in = cell_i;
      for (int l = 0; l < 3; l++) begin
         if (!cell_i.lane[l].z[33]) begin
            cell_in.lane[l].x = cell_i.lane[l].x - (cell_i.lane[l].y >>> stage_i);
            cell_in.lane[l].y = cell_i.lane[l].y + (cell_i.lane[l].x >>> stage_i);
            cell_in.lane[l].z = cell_i.lane[l].z - atan_val;
         end else begin
            cell_in.lane[l].x = cell_i.lane[l].x + (cell_i.lane[l].y >>> stage_i);
            cell_in.lane[l].y = cell_i.lane[l].y - (cell_i.lane[l].x >>> stage_i);
            cell_in.lane[l].z = cell_i.lane[l].z + atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

@@ sv/etm_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// etm_matrix_unit: rotation entries, scaling and result sequencing
// Multiplies are registered in stages B and C and in the sequencer; four results leave per item.
// ----------------------------------------------------------------------------
module etm_matrix_unit
   import etm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_type           cell_i,
   output logic               take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_elem_0,
   output logic signed [31:0] rsp_elem_1,
   output logic signed [31:0] rsp_elem_2,
   output logic signed [31:0] rsp_elem_3,
   output logic               rsp_last
);

   `include "assert_macros.svh"

   // stage A: rounded sines/cosines
   logic signed [17:0] s_a [3], c_a [3];
   logic signed [17:0] s_ff [3], c_ff [3];
   logic               a_vld_ff;
   logic signed [31:0] pos_a_ff [3], scl_a_ff [3];

   function automatic logic signed [17:0] to_q16(input logic signed [33:0] v, input logic n);
      logic signed [33:0] r;
      logic signed [17:0] q;
      r = (v + 34'sd8192) >>> 14;
      if (r > 34'sd65536) q = 18'sd65536;
      else if (r < -34'sd65536) q = -18'sd65536;
      else q = r[17:0];
      return n ? -q : q;
   endfunction

   // stage B: pair products at 2^32
   logic signed [35:0] cz_sy_ff, sz_sy_ff, cz_cy_ff, sz_cy_ff, cy_sx_ff, cy_cx_ff;
   logic signed [35:0] sz_cx_ff, sz_sx_ff, cz_cx_ff, cz_sx_ff;
   logic signed [17:0] sx_b_ff, cx_b_ff, sy_b_ff;
   logic               b_vld_ff;
   logic signed [31:0] pos_b_ff [3], scl_b_ff [3];

   // stage C: rotation entries rounded from 2^48 to 2^16
   logic signed [31:0] r_ff [3][3];
   logic               c_vld_ff;
   logic signed [31:0] pos_c_ff [3], scl_c_ff [3];

   // output sequencer with row counter
   logic [1:0]         row_ff;
   logic               busy_ff;
   logic signed [31:0] r_hold_ff [3][3];
   logic signed [31:0] pos_h_ff [3], scl_h_ff [3];
   logic               s_vld_ff;
   logic [1:0]         s_row_ff;
   logic signed [63:0] p_ff [3];
   logic signed [31:0] s_pos_ff;

   logic adv_s, out_free, pipe_adv, row_step;
   assign out_free = !rsp_valid || rsp_ready;
   assign adv_s    = out_free;
   // pipeline moves when stage C is empty or the hold register is free to take it
   assign pipe_adv = !c_vld_ff || (!busy_ff) || (adv_s && busy_ff && row_ff == 2'd3);
   assign take     = pipe_adv;
   assign row_step = busy_ff && adv_s && (row_ff != 2'd3);

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         s_a[l] = to_q16(cell_i.lane[l].y, cell_i.lane[l].neg);
         c_a[l] = to_q16(cell_i.lane[l].x, cell_i.lane[l].neg);
      end
   end

   function automatic logic signed [31:0] rnd48(input logic signed [53:0] v);
      logic signed [53:0] t;
      t = (v + 54'sh80000000) >>> 32;
      return t[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (pipe_adv) begin
         a_vld_ff <= cell_i.vld;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         for (int l = 0; l < 3; l++) begin
            s_ff[l] <= s_a[l];
            c_ff[l] <= c_a[l];
         end
         pos_a_ff[0] <= cell_i.pos_x; pos_a_ff[1] <= cell_i.pos_y; pos_a_ff[2] <= cell_i.pos_z;
         scl_a_ff[0] <= cell_i.scl_x; scl_a_ff[1] <= cell_i.scl_y; scl_a_ff[2] <= cell_i.scl_z;
         cz_sy_ff <= 36'(c_ff[2] * s_ff[1]);
         sz_sy_ff <= 36'(s_ff[2] * s_ff[1]);
         cz_cy_ff <= 36'(c_ff[2] * c_ff[1]);
         sz_cy_ff <= 36'(s_ff[2] * c_ff[1]);
         cy_sx_ff <= 36'(c_ff[1] * s_ff[0]);
         cy_cx_ff <= 36'(c_ff[1] * c_ff[0]);
         sz_cx_ff <= 36'(s_ff[2] * c_ff[0]);
         sz_sx_ff <= 36'(s_ff[2] * s_ff[0]);
         cz_cx_ff <= 36'(c_ff[2] * c_ff[0]);
         cz_sx_ff <= 36'(c_ff[2] * s_ff[0]);
         sx_b_ff  <= s_ff[0];
         cx_b_ff  <= c_ff[0];
         sy_b_ff  <= s_ff[1];
         pos_b_ff <= pos_a_ff;
         scl_b_ff <= scl_a_ff;
         r_ff[0][0] <= rnd48(54'(cz_cy_ff) <<< 16);
         r_ff[0][1] <= rnd48(54'(cz_sy_ff * sx_b_ff) - (54'(sz_cx_ff) <<< 16));
         r_ff[0][2] <= rnd48(54'(cz_sy_ff * cx_b_ff) + (54'(sz_sx_ff) <<< 16));
         r_ff[1][0] <= rnd48(54'(sz_cy_ff) <<< 16);
         r_ff[1][1] <= rnd48(54'(sz_sy_ff * sx_b_ff) + (54'(cz_cx_ff) <<< 16));
         r_ff[1][2] <= rnd48(54'(sz_sy_ff * cx_b_ff) - (54'(cz_sx_ff) <<< 16));
         r_ff[2][0] <= rnd48(-(54'(sy_b_ff) <<< 32));
         r_ff[2][1] <= rnd48(54'(cy_sx_ff) <<< 16);
         r_ff[2][2] <= rnd48(54'(cy_cx_ff) <<< 16);
         pos_c_ff <= pos_b_ff;
         scl_c_ff <= scl_b_ff;
      end
   end

   // hold register cycles through four rows
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
         s_vld_ff <= 1'b0;
      end else if (adv_s) begin
         s_vld_ff <= busy_ff;
         if (busy_ff && row_ff != 2'd3) begin
            row_ff <= row_ff + 2'd1;
         end else begin
            busy_ff <= c_vld_ff && pipe_adv;
            row_ff  <= '0;
         end
      end else if (!busy_ff && c_vld_ff && pipe_adv) begin
         busy_ff <= 1'b1;
         row_ff  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv && c_vld_ff) begin
         r_hold_ff <= r_ff;
         pos_h_ff  <= pos_c_ff;
         scl_h_ff  <= scl_c_ff;
      end
      if (adv_s) begin
         s_row_ff <= row_ff;
         s_pos_ff <= (row_ff == 2'd3) ? 32'sd0 : pos_h_ff[row_ff];
         for (int j = 0; j < 3; j++) begin
            if (row_ff == 2'd3)
               p_ff[j] <= 64'(r_hold_ff[j][2]);
            else
               p_ff[j] <= r_hold_ff[row_ff][j] * scl_h_ff[j];
         end
      end
   end

   function automatic logic signed [31:0] sat_q(input logic signed [63:0] p, input logic fwd);
      logic signed [63:0] t;
      t = fwd ? p : ((p + 64'sd32768) >>> 16);
      if (t > 64'sd2147483647) return 32'sh7fffffff;
      if (t < -64'sd2147483648) return 32'sh80000000;
      return t[31:0];
   endfunction

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_free) begin
         rsp_valid <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_row_index <= s_row_ff;
         rsp_elem_0    <= sat_q(p_ff[0], s_row_ff == 2'd3);
         rsp_elem_1    <= sat_q(p_ff[1], s_row_ff == 2'd3);
         rsp_elem_2    <= sat_q(p_ff[2], s_row_ff == 2'd3);
         rsp_elem_3    <= s_pos_ff;
         rsp_last      <= s_row_ff == 2'd3;
      end
   end

   `ASSERT_ALWAYS(a_last_row, !rsp_valid || rsp_last == (rsp_row_index == 2'd3), "bad last flag")
   `ASSERT_NEXT(a_row_seq, row_step, row_ff == $past(row_ff) + 2'd1, "row sequence skipped")
   `ASSERT_ALWAYS(a_fwd_zero, !(rsp_valid && rsp_last) || rsp_elem_3 == 32'sd0, "bad forward elem_3")

endmodule

@@ verif/euler_trs_model_matrix_top_tb.sv @@
// ----------------------------------------------------------------------------
// euler_trs_model_matrix_top_tb: self-checking bench for the model matrix block
// Sends position, Euler angle and scale items, predicts the three matrix rows
// and the forward vector per item, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module euler_trs_model_matrix_top_tb;
   import etm_pkg::*;

   typedef struct {
      logic [31:0] pos [3];
      logic [15:0] ang [3];
      logic [31:0] scl [3];
   } trs_item_type;

   typedef struct {
      logic [1:0]  row;
      logic [31:0] elem [4];
      logic        last;
   } row_result_type;

   localparam longint ATAN_TURN32 [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
   localparam longint GAIN_INV = 652032874;
   localparam longint QTURN    = 1073741824;
   localparam longint ONE_Q16  = 65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [15:0] req_angle_x = '0, req_angle_y = '0, req_angle_z = '0;
   logic signed [31:0] req_scale_x = '0, req_scale_y = '0, req_scale_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_row_index;
   logic signed [31:0] rsp_elem_0, rsp_elem_1, rsp_elem_2, rsp_elem_3;
   logic rsp_last;

   trs_item_type   pending_items [$];
   row_result_type expected_rows [$];
   int             error_count = 0;
   int             rows_seen = 0;
   int             send_gap = 0;
   int             recv_gap = 0;
   bit             long_hold_done = 1'b0;

   euler_trs_model_matrix_top dut (.*);

   always #5 clock = ~clock;

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint round_q16(longint v);
      longint r;
      r = (v + 8192) >>> 14;
      if (r > ONE_Q16) r = ONE_Q16;
      if (r < -ONE_Q16) r = -ONE_Q16;
      return r;
   endfunction

   function automatic void cordic_sincos(input logic [15:0] ang,
                                         output longint s, output longint c);
      longint z, x, y, nx;
      bit     flip;
      z = longint'($signed({ang, 16'h0000}));
      x = GAIN_INV;
      y = 0;
      flip = 1'b0;
      // fold into +-quarter turn, negate both outputs afterwards
      if (z > QTURN) begin
         z -= 2 * QTURN;
         flip = 1'b1;
      end else if (z < -QTURN) begin
         z += 2 * QTURN;
         flip = 1'b1;
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ATAN_TURN32[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ATAN_TURN32[i];
         end
         x = nx;
      end
      c = round_q16(x);
      s = round_q16(y);
      if (flip) begin
         c = -c;
         s = -s;
      end
   endfunction

   function automatic longint round_rot(longint v);
      return (v + 64'sh80000000) >>> 32;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic predict_model_rows(input trs_item_type it);
      longint sx, cx, sy, cy, sz, cz, e;
      longint rot [3][3];
      row_result_type res;
      cordic_sincos(it.ang[0], sx, cx);
      cordic_sincos(it.ang[1], sy, cy);
      cordic_sincos(it.ang[2], sz, cz);
      rot[0][0] = round_rot(cz * cy * ONE_Q16);
      rot[0][1] = round_rot(cz * sy * sx - sz * cx * ONE_Q16);
      rot[0][2] = round_rot(cz * sy * cx + sz * sx * ONE_Q16);
      rot[1][0] = round_rot(sz * cy * ONE_Q16);
      rot[1][1] = round_rot(sz * sy * sx + cz * cx * ONE_Q16);
      rot[1][2] = round_rot(sz * sy * cx - cz * sx * ONE_Q16);
      rot[2][0] = round_rot(-sy * ONE_Q16 * ONE_Q16);
      rot[2][1] = round_rot(cy * sx * ONE_Q16);
      rot[2][2] = round_rot(cy * cx * ONE_Q16);
      for (int k = 0; k < 3; k++) begin
         res.row = 2'(k);
         for (int j = 0; j < 3; j++) begin
            e = clamp32((rot[k][j] * longint'($signed(it.scl[j])) + 32768) >>> 16);
            res.elem[j] = e[31:0];
         end
         res.elem[3] = it.pos[k];
         res.last = 1'b0;
         expected_rows.push_back(res);
      end
      res.row = 2'd3;
      for (int j = 0; j < 3; j++) begin
         e = clamp32(rot[j][2]);
         res.elem[j] = e[31:0];
      end
      res.elem[3] = '0;
      res.last = 1'b1;
      expected_rows.push_back(res);
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch at row transfer %0d: %s got %h expected %h",
               rows_seen, field, got, want);
      error_count++;
   endtask

   task automatic queue_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [31:0] kx, logic [31:0] ky, logic [31:0] kz);
      trs_item_type it;
      it.pos = '{px, py, pz};
      it.ang = '{ax, ay, az};
      it.scl = '{kx, ky, kz};
      pending_items.push_back(it);
   endtask

   function automatic logic [31:0] rand_scale();
      if ($urandom_range(0, 1)) return $urandom();
      // otherwise near unit scale, both signs
      return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
   endfunction

   function automatic logic [15:0] rand_angle();
      logic [15:0] edges [8] = '{16'h0000, 16'h4000, 16'h4001, 16'h8000,
                                 16'hBFFF, 16'hC000, 16'hFFFF, 16'h3FFF};
      if ($urandom_range(0, 9) == 0) return edges[$urandom_range(0, 7)];
      return 16'($urandom());
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            trs_item_type it;
            it = pending_items.pop_front();
            req_pos_x <= it.pos[0];
            req_pos_y <= it.pos[1];
            req_pos_z <= it.pos[2];
            req_angle_x <= it.ang[0];
            req_angle_y <= it.ang[1];
            req_angle_z <= it.ang[2];
            req_scale_x <= it.scl[0];
            req_scale_y <= it.scl[1];
            req_scale_z <= it.scl[2];
            req_valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict on every accepted input transfer
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         trs_item_type it;
         it.pos = '{req_pos_x, req_pos_y, req_pos_z};
         it.ang = '{req_angle_x, req_angle_y, req_angle_z};
         it.scl = '{req_scale_x, req_scale_y, req_scale_z};
         predict_model_rows(it);
      end
   end

   // monitor and result-side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               $display("unexpected row transfer %0d", rows_seen);
               error_count++;
            end else begin
               row_result_type want;
               want = expected_rows.pop_front();
               if (rsp_row_index !== want.row)
                  report_mismatch("row_index", 32'(rsp_row_index), 32'(want.row));
               if (rsp_elem_0 !== want.elem[0]) report_mismatch("elem_0", rsp_elem_0, want.elem[0]);
               if (rsp_elem_1 !== want.elem[1]) report_mismatch("elem_1", rsp_elem_1, want.elem[1]);
               if (rsp_elem_2 !== want.elem[2]) report_mismatch("elem_2", rsp_elem_2, want.elem[2]);
               if (rsp_elem_3 !== want.elem[3]) report_mismatch("elem_3", rsp_elem_3, want.elem[3]);
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
            rows_seen <= rows_seen + 1;
         end
         // one long hold-off to back the pipeline up into the input side
         if (!long_hold_done && rows_seen >= 200) begin
            long_hold_done <= 1'b1;
            recv_gap <= 400;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
         end
      end
   end

   initial begin
      // directed: unit/identity, quadrant edges, field extremes, saturation
      queue_item(0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 32'h10000, 32'h10000, 32'h10000);
      queue_item(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'h4000, 16'h0000, 16'h0000,
                 32'h10000, 32'h10000, 32'h10000);
      queue_item(1, 2, 3, 16'h0000, 16'h4000, 16'h0000, 32'h10000, 32'h10000, 32'h10000);
      queue_item(1, 2, 3, 16'h0000, 16'h0000, 16'h4000, 32'h10000, 32'h10000, 32'h10000);
      queue_item(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 32'h10000, 32'h10000, 32'h10000);
      queue_item(0, 0, 0, 16'hC000, 16'hC000, 16'hC000, 32'h10000, 32'h10000, 32'h10000);
      queue_item(0, 0, 0, 16'h4001, 16'hBFFF, 16'hFFFF, 32'h10000, 32'h10000, 32'h10000);
      queue_item(0, 0, 0, 16'h3FFF, 16'hC001, 16'h0001, 32'hFFFF0000, 32'h20000, 32'h8000);
      queue_item(0, 0, 0, 16'h0000, 16'h0000, 16'h0000,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      queue_item(0, 0, 0, 16'h0000, 16'h0000, 16'h0000,
                 32'h80000000, 32'h80000000, 32'h80000000);
      queue_item(0, 0, 0, 16'h8000, 16'h0000, 16'h8000,
                 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      queue_item(0, 0, 0, 16'h2000, 16'h2000, 16'h2000,
                 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      queue_item(32'h80000000, 32'h7FFFFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);
      queue_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_item(32'h55555555, 32'hAAAAAAAA, 32'h12345678, 16'h5555, 16'hAAAA, 16'h1234,
                 32'h00000001, 32'hFFFFFFFF, 32'h00010001);
      queue_item(0, 0, 0, 16'h6000, 16'hA000, 16'hE000, 32'h10000, 32'hFFFF0000, 32'h10000);
      for (int n = 0; n < 455; n++)
         queue_item($urandom(), $urandom(), $urandom(), rand_angle(), rand_angle(),
                    rand_angle(), rand_scale(), rand_scale(), rand_scale());
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_rows.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/etm_pkg.sv
sv/etm_cordic_cell.sv
sv/etm_matrix_unit.sv
sv/euler_trs_model_matrix_top.sv
verif/euler_trs_model_matrix_top_tb.sv
